@@ sv/arot_pkg.sv @@
// Shared types, codes and widths for the address range owner table.
package arot_pkg;

  localparam int ADDR_BITS     = 48;
  localparam int OWNER_BITS    = 8;
  localparam int TABLE_ENTRIES = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_FIND,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [ADDR_BITS-1:0]  address;
    logic [ADDR_BITS-1:0]  length;
    logic [OWNER_BITS-1:0] owner_id;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  hit;
    logic [OWNER_BITS-1:0] found_owner;
  } out_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_BITS-1:0]  address;
    logic [ADDR_BITS-1:0]  length;
    logic [OWNER_BITS-1:0] owner_id;
  } qitem_t;

endpackage

@@ sv/arot_fifo.sv @@
// Short queue of classified items between front and back.
module arot_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  arot_pkg::qitem_t push_item,
  input  logic            pop,
  output arot_pkg::qitem_t pop_item,
  output logic            full,
  output logic            empty
);

  localparam int IDX_BITS = $clog2(arot_pkg::QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(arot_pkg::QUEUE_DEPTH + 1);

  arot_pkg::qitem_t        slots_r [arot_pkg::QUEUE_DEPTH];
  logic [IDX_BITS-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]     count_r;

  assign full     = (count_r == CNT_BITS'(arot_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == IDX_BITS'(arot_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == IDX_BITS'(arot_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_BITS'(push && !full) - CNT_BITS'(pop && !empty);
    end
  end

endmodule

@@ sv/arot_front.sv @@
// Front end: accepts request items and classifies them into queue operations.
module arot_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  arot_pkg::in_t     in_data,
  input  logic              q_full,
  output logic              q_push,
  output arot_pkg::qitem_t  q_item
);

  arot_pkg::op_t op;

  always_comb begin
    unique case (in_data.req_type)
      arot_pkg::REQ_ADD:    op = (in_data.length == '0) ? arot_pkg::OP_NOP : arot_pkg::OP_ADD;
      arot_pkg::REQ_REMOVE: op = arot_pkg::OP_REMOVE;
      arot_pkg::REQ_FIND:   op = arot_pkg::OP_FIND;
      default:              op = arot_pkg::OP_NOP;
    endcase
  end

  assign in_ready         = !q_full;
  assign q_push           = in_valid && !q_full;
  assign q_item.op        = op;
  assign q_item.address   = in_data.address;
  assign q_item.length    = in_data.length;
  assign q_item.owner_id  = in_data.owner_id;

endmodule

@@ sv/arot_table.sv @@
// Back end: sorted cell chain that inserts, removes and looks up ranges.
module arot_table #(
  parameter int TABLE_ENTRIES = arot_pkg::TABLE_ENTRIES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  arot_pkg::qitem_t q_item,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output arot_pkg::out_t   out_data
);

  localparam int AB = arot_pkg::ADDR_BITS;
  localparam int OB = arot_pkg::OWNER_BITS;
  localparam int N  = TABLE_ENTRIES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXE,
    S_CHK
  } state_t;

  state_t             state_r;
  arot_pkg::qitem_t   cur_r;
  logic               out_valid_r;
  arot_pkg::out_t     out_r;

  // Cells are kept sorted by base, valid ones packed at the low end.
  logic [N-1:0]       valid_r;
  logic [AB-1:0]      base_r [N];
  logic [AB-1:0]      len_r  [N];
  logic [OB-1:0]      own_r  [N];

  logic [N-1:0]       le_r, eq_r;
  logic [N-1:0]       le_nxt, eq_nxt, sel;

  logic [N-1:0]       up_valid, dn_le, up_le;
  logic [AB-1:0]      up_base [N];
  logic [AB-1:0]      up_len  [N];
  logic [OB-1:0]      up_own  [N];
  logic [AB-1:0]      dn_base [N];
  logic [AB-1:0]      dn_len  [N];
  logic [OB-1:0]      dn_own  [N];

  logic [AB-1:0]      sel_base_r, sel_len_r;
  logic [OB-1:0]      sel_own_r;
  logic               sel_any_r;
  logic [AB-1:0]      sel_base_nxt, sel_len_nxt;
  logic [OB-1:0]      sel_own_nxt;
  logic [AB-1:0]      diff;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign le_nxt[g] = valid_r[g] && (base_r[g] <= cur_r.address);
      assign eq_nxt[g] = valid_r[g] && (base_r[g] == cur_r.address);
      if (g == N - 1) begin : g_top
        assign up_valid[g] = 1'b0;
        assign up_le[g]    = 1'b0;
        assign up_base[g]  = base_r[g];
        assign up_len[g]   = len_r[g];
        assign up_own[g]   = own_r[g];
      end else begin : g_mid
        assign up_valid[g] = valid_r[g+1];
        assign up_le[g]    = le_r[g+1];
        assign up_base[g]  = base_r[g+1];
        assign up_len[g]   = len_r[g+1];
        assign up_own[g]   = own_r[g+1];
      end
      if (g == 0) begin : g_bot
        assign dn_le[g]   = 1'b1;
        assign dn_base[g] = cur_r.address;
        assign dn_len[g]  = cur_r.length;
        assign dn_own[g]  = cur_r.owner_id;
      end else begin : g_upper
        assign dn_le[g]   = le_r[g-1];
        assign dn_base[g] = base_r[g-1];
        assign dn_len[g]  = len_r[g-1];
        assign dn_own[g]  = own_r[g-1];
      end
      // Predecessor is the last cell whose base is not above the address.
      assign sel[g] = le_r[g] && !up_le[g];
    end
  endgenerate

  always_comb begin
    sel_base_nxt = '0;
    sel_len_nxt  = '0;
    sel_own_nxt  = '0;
    for (int i = 0; i < N; i++) begin
      if (sel[i]) begin
        sel_base_nxt = base_r[i];
        sel_len_nxt  = len_r[i];
        sel_own_nxt  = own_r[i];
      end
    end
  end

  assign diff      = cur_r.address - sel_base_r;
  assign q_pop     = (state_r == S_IDLE) && !q_empty && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Cell payload: shift up on insert, down on remove.
  always_ff @(posedge clk) begin
    if (state_r == S_EXE) begin
      for (int i = 0; i < N; i++) begin
        if (cur_r.op == arot_pkg::OP_ADD && eq_r == '0 && !valid_r[N-1] && !le_r[i]) begin
          if (dn_le[i]) begin
            base_r[i] <= cur_r.address;
            len_r[i]  <= cur_r.length;
            own_r[i]  <= cur_r.owner_id;
          end else begin
            base_r[i] <= dn_base[i];
            len_r[i]  <= dn_len[i];
            own_r[i]  <= dn_own[i];
          end
        end else if (cur_r.op == arot_pkg::OP_REMOVE && eq_r != '0
                     && (eq_r[i] || !le_r[i])) begin
          base_r[i] <= up_base[i];
          len_r[i]  <= up_len[i];
          own_r[i]  <= up_own[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cur_r   <= q_item;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          le_r    <= le_nxt;
          eq_r    <= eq_nxt;
          state_r <= S_EXE;
        end
        S_EXE: begin
          out_r.hit         <= 1'b0;
          out_r.found_owner <= '0;
          sel_base_r        <= sel_base_nxt;
          sel_len_r         <= sel_len_nxt;
          sel_own_r         <= sel_own_nxt;
          sel_any_r         <= (sel != '0);
          if (cur_r.op == arot_pkg::OP_FIND) begin
            state_r <= S_CHK;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
          unique case (cur_r.op)
            arot_pkg::OP_ADD: begin
              if (eq_r != '0) begin
                out_r.status <= arot_pkg::ST_DUP;
              end else if (valid_r[N-1]) begin
                out_r.status <= arot_pkg::ST_FULL;
              end else begin
                out_r.status <= arot_pkg::ST_OK;
                for (int i = 0; i < N; i++) begin
                  if (!le_r[i]) begin
                    valid_r[i] <= dn_le[i] ? 1'b1 : valid_r[i-((i > 0) ? 1 : 0)];
                  end
                end
              end
            end
            arot_pkg::OP_REMOVE: begin
              out_r.status <= arot_pkg::ST_OK;
              if (eq_r != '0) begin
                for (int i = 0; i < N; i++) begin
                  if (eq_r[i] || !le_r[i]) begin
                    valid_r[i] <= up_valid[i];
                  end
                end
              end
            end
            default: out_r.status <= arot_pkg::ST_OK;
          endcase
        end
        S_CHK: begin
          // Address is at or above the selected base, so the difference fits.
          if (sel_any_r && diff < sel_len_r) begin
            out_r.hit         <= 1'b1;
            out_r.found_owner <= sel_own_r;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/address_range_owner_table.sv @@
// Top level of the address range owner table.
// Each item is popped from the queue, compared, then executed (and range checked for
// find); the back pops the next item only after the result has left, so it works on
// one item at a time. A 2-item queue lets the front accept while the back works.
// Synchronous active-low reset empties the table and the queue.
module address_range_owner_table #(
  parameter int TABLE_ENTRIES = arot_pkg::TABLE_ENTRIES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  arot_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output arot_pkg::out_t  out_data
);

  arot_pkg::qitem_t push_item, pop_item;
  logic             q_push, q_pop, q_full, q_empty;

  arot_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  arot_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  arot_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (pop_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/arot_checker.sv @@
// Port-level checks for the address range owner table, with its bind.
module arot_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input arot_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("unused status code");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.status == arot_pkg::ST_OK)
    else $error("hit with error status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.found_owner == '0)
    else $error("owner reported on miss");

endmodule

bind address_range_owner_table arot_checker u_arot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ verif/tb.sv @@
// Self-checking testbench for the address range owner table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1250;
  localparam int AB = arot_pkg::ADDR_BITS;
  localparam int OB = arot_pkg::OWNER_BITS;
  localparam int TE = arot_pkg::TABLE_ENTRIES;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  arot_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  arot_pkg::out_t out_data;

  address_range_owner_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the range table
  logic          tbl_valid [TE];
  logic [AB-1:0] tbl_base  [TE];
  logic [AB-1:0] tbl_len   [TE];
  logic [OB-1:0] tbl_owner [TE];

  arot_pkg::in_t  pending_reqs[$];
  arot_pkg::out_t expected_results[$];
  logic [AB-1:0]  used_bases[$];
  int   errors = 0;
  bit   stim_done = 1'b0;

  function automatic arot_pkg::out_t lookup_owner(arot_pkg::in_t req);
    arot_pkg::out_t r;
    int slot;
    int best;
    r = '0;
    slot = -1;
    best = -1;
    for (int k = 0; k < TE; k++)
      if (tbl_valid[k] && tbl_base[k] == req.address && slot < 0) slot = k;
    case (req.req_type)
      arot_pkg::REQ_ADD: begin
        if (req.length != 0) begin
          if (slot >= 0) begin
            r.status = arot_pkg::ST_DUP;
          end else begin
            for (int k = 0; k < TE; k++)
              if (!tbl_valid[k] && best < 0) best = k;
            if (best < 0) begin
              r.status = arot_pkg::ST_FULL;
            end else begin
              tbl_valid[best] = 1'b1;
              tbl_base[best]  = req.address;
              tbl_len[best]   = req.length;
              tbl_owner[best] = req.owner_id;
            end
          end
        end
      end
      arot_pkg::REQ_REMOVE: begin
        if (slot >= 0) tbl_valid[slot] = 1'b0;
      end
      arot_pkg::REQ_FIND: begin
        for (int k = 0; k < TE; k++)
          if (tbl_valid[k] && tbl_base[k] <= req.address)
            if (best < 0 || tbl_base[k] > tbl_base[best]) best = k;
        if (best >= 0 && (req.address - tbl_base[best]) < tbl_len[best]) begin
          r.hit = 1'b1;
          r.found_owner = tbl_owner[best];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_req(logic [1:0] op, logic [AB-1:0] a,
                                    logic [AB-1:0] l, logic [OB-1:0] o);
    arot_pkg::in_t t;
    t.req_type = op;
    t.address = a;
    t.length = l;
    t.owner_id = o;
    pending_reqs.push_back(t);
    if (op == arot_pkg::REQ_ADD) used_bases.push_back(a);
  endfunction

  function automatic logic [AB-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[AB-1:0];
  endfunction

  // Driver: one item at a time with a random gap ahead of each
  int gap_in = 0;
  always @(posedge clk) begin : drive
    int wait_in;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(lookup_owner(in_data));
        wait_in = $urandom_range(0, 14);
        if (wait_in == 0 && pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          gap_in  <= 0;
        end else begin
          in_valid <= 1'b0;
          gap_in   <= (wait_in > 0) ? wait_in - 1 : 0;
        end
      end else if (!in_valid) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: random stalls on the result side
  int gap_out = 0;
  always @(posedge clk) begin : monitor
    arot_pkg::out_t e;
    int wait_out;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation: status=%0d hit=%0d owner=%0d",
                 out_data.status, out_data.hit, out_data.found_owner);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data.status);
            errors++;
          end
          if (out_data.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, out_data.hit);
            errors++;
          end
          if (out_data.found_owner !== e.found_owner) begin
            $error("found_owner: expected %0d, got %0d", e.found_owner, out_data.found_owner);
            errors++;
          end
        end
        wait_out = $urandom_range(0, 14);
        if (wait_out == 0) begin
          gap_out   <= 0;
          out_ready <= 1'b1;
        end else begin
          gap_out   <= wait_out - 1;
          out_ready <= 1'b0;
        end
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [AB-1:0] b;
    logic [AB-1:0] amax;
    int r;
    amax = '1;
    for (int k = 0; k < TE; k++) tbl_valid[k] = 1'b0;
    // Directed: extremes, every request, zero length, duplicate, full, unused code
    queue_req(arot_pkg::REQ_FIND, '0, '0, '0);
    queue_req(arot_pkg::REQ_ADD, '0, amax, 8'hFF);
    queue_req(arot_pkg::REQ_ADD, '0, 48'd5, 8'h01);
    queue_req(arot_pkg::REQ_FIND, amax, '0, '0);
    queue_req(arot_pkg::REQ_ADD, amax, amax, 8'hA5);
    queue_req(arot_pkg::REQ_FIND, amax, '0, '0);
    queue_req(arot_pkg::REQ_ADD, 48'h1000, '0, 8'h11);
    queue_req(arot_pkg::REQ_FIND, 48'h1000, '0, '0);
    queue_req(arot_pkg::REQ_ADD, 48'h1000, 48'h10, 8'h22);
    queue_req(arot_pkg::REQ_FIND, 48'h100F, '0, '0);
    queue_req(arot_pkg::REQ_FIND, 48'h1010, '0, '0);
    queue_req(arot_pkg::REQ_REMOVE, 48'h1000, amax, 8'hFF);
    queue_req(arot_pkg::REQ_REMOVE, 48'h1000, '0, '0);
    queue_req(arot_pkg::REQ_FIND, 48'h1005, '0, '0);
    queue_req(arot_pkg::OP_NOP, amax, amax, 8'hFF);
    queue_req(arot_pkg::REQ_REMOVE, '0, '0, '0);
    queue_req(arot_pkg::REQ_REMOVE, amax, '0, '0);
    // Fill the table, then hit both full and duplicate-while-full
    for (int k = 0; k < TE; k++)
      queue_req(arot_pkg::REQ_ADD, AB'(48'h10_0000 * (k + 1)), 48'h8_0000, k[7:0]);
    queue_req(arot_pkg::REQ_ADD, 48'h7, 48'h1, 8'h33);
    queue_req(arot_pkg::REQ_ADD, 48'h10_0000, 48'h1, 8'h33);
    queue_req(arot_pkg::REQ_FIND, 48'h20_0004, '0, '0);
    for (int k = 0; k < TE; k++)
      queue_req(arot_pkg::REQ_REMOVE, AB'(48'h10_0000 * (k + 1)), '0, '0);
    // Random: mostly clustered ranges so finds and removes land on real entries
    for (int i = 0; i < NUM_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        b = rand_addr();
      end else if (used_bases.size() > 0 && r < 60) begin
        b = used_bases[$urandom_range(0, used_bases.size() - 1)]
            + AB'($urandom_range(0, 3) * $urandom_range(0, 300));
      end else begin
        b = AB'($urandom_range(0, 1 << 14));
      end
      if (r < 3) b = amax - AB'($urandom_range(0, 10));
      if (r < 40)
        queue_req(arot_pkg::REQ_ADD, b, (r < 4) ? rand_addr() : AB'($urandom_range(0, 400)),
                  OB'($urandom_range(0, 255)));
      else if (r < 55)
        queue_req(arot_pkg::REQ_REMOVE, b, rand_addr(), OB'($urandom_range(0, 255)));
      else if (r < 98)
        queue_req(arot_pkg::REQ_FIND, b, rand_addr(), OB'($urandom_range(0, 255)));
      else
        queue_req(arot_pkg::OP_NOP, b, rand_addr(), OB'($urandom_range(0, 255)));
      if (used_bases.size() > 200) void'(used_bases.pop_front());
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid || expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    stim_done = 1'b1;
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2ms;
    if (!stim_done) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule

@@ filelist.f @@
sv/arot_pkg.sv
sv/arot_fifo.sv
sv/arot_front.sv
sv/arot_table.sv
sv/address_range_owner_table.sv
sv/arot_checker.sv
verif/tb.sv
